@@ sv/vlmr_pkg.sv @@
// ----------------------------------------------------------------------------
// vlmr_pkg
// Shared types and constants of the variable-length message ring.
// ----------------------------------------------------------------------------
package vlmr_pkg;

    localparam int LEN_W  = 12;
    localparam int DATA_W = 8;
    localparam int ST_W   = 3;

    typedef enum logic [1:0]
    {
        OP_RESERVE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_BAD     = 2'd3
    } op_t;

    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
    localparam logic [ST_W-1:0] ST_BADLEN = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [ST_W-1:0] ST_SEQ   = 3'd4;

    typedef struct packed
    {
        op_t               op;
        logic              zero_len;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } item_t;

endpackage

@@ sv/variable_length_message_ring.sv @@
// ----------------------------------------------------------------------------
// variable_length_message_ring
// Byte ring of length-prefixed messages behind queue-style ports.
// ----------------------------------------------------------------------------
// A write word stores its byte; a reserve word writes the length header, after
// an all-ones marker if it wraps. A read word reads the header at a message
// start, and the next header past a marker, then one body byte. Rejected words
// go straight to the result. One word is in work at a time, taken once the last
// result is loaded. The single-port byte store allows one access a cycle.
// Reset clears offsets, counts and queues; the byte store is left as is.
module variable_length_message_ring
    import vlmr_pkg::*;
#(
    parameter int BUF_BYTES = 4096,
    parameter int HDR_BYTES = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        operation,
    input  logic [LEN_W-1:0]  msg_length,
    input  logic [DATA_W-1:0] data_in,
    output logic              empty,
    input  logic              pop,
    output logic [ST_W-1:0]   status,
    output logic [DATA_W-1:0] data_out,
    output logic              last_byte,
    output logic [LEN_W-1:0]  read_length
);

    logic  item_valid;
    item_t item;
    logic  item_take;

    vlmr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .msg_length (msg_length),
        .data_in    (data_in),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    vlmr_back #(
        .BUF_BYTES (BUF_BYTES),
        .HDR_BYTES (HDR_BYTES)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .data_out    (data_out),
        .last_byte   (last_byte),
        .read_length (read_length)
    );

endmodule

@@ sv/vlmr_front.sv @@
// ----------------------------------------------------------------------------
// vlmr_front
// Accepts words, classifies the operation and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module vlmr_front
    import vlmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        operation,
    input  logic [LEN_W-1:0]  msg_length,
    input  logic [DATA_W-1:0] data_in,
    output logic              item_valid,
    output item_t             item,
    input  logic              item_take
);

    item_t      slot_reg [2];
    logic       rd_reg;
    logic       wr_reg;
    logic [1:0] count_reg;
    item_t      incoming;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        case (operation)
            OP_RESERVE: incoming.op = OP_RESERVE;
            OP_WRITE:   incoming.op = OP_WRITE;
            OP_READ:    incoming.op = OP_READ;
            default:    incoming.op = OP_BAD;
        endcase
        incoming.zero_len = (msg_length == '0);
        incoming.len      = msg_length;
        incoming.data     = data_in;
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wr_reg] <= incoming;
                wr_reg           <= !wr_reg;
            end
            if (do_pop)
                rd_reg <= !rd_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

@@ sv/vlmr_back.sv @@
// ----------------------------------------------------------------------------
// vlmr_back
// Carries out reserve, write and read words on the byte store; holds a result.
// ----------------------------------------------------------------------------
module vlmr_back
    import vlmr_pkg::*;
#(
    parameter int BUF_BYTES = 4096,
    parameter int HDR_BYTES = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  item_t             item,
    output logic              item_take,
    output logic              empty,
    input  logic              pop,
    output logic [ST_W-1:0]   status,
    output logic [DATA_W-1:0] data_out,
    output logic              last_byte,
    output logic [LEN_W-1:0]  read_length
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 2;
    localparam int KW = (HDR_BYTES > 2) ? 2 : 1;
    localparam logic [KW-1:0] K_LAST = KW'(HDR_BYTES - 1);
    localparam logic [CW-1:0] BUF_C  = CW'(BUF_BYTES);
    localparam logic [CW-1:0] HDR2_C = CW'(2 * HDR_BYTES);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_WR,
        S_MARK,
        S_HDRW,
        S_HRD,
        S_HCOL,
        S_BRD,
        S_BCOL,
        S_DONE
    } state_t;

    state_t              state_reg;
    item_t               it_reg;
    logic [KW-1:0]       k_reg;
    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       tail_reg;
    logic                wrapped_reg;
    logic [AW-1:0]       wp_reg;
    logic [LEN_W-1:0]    wrem_reg;
    logic [AW-1:0]       rp_reg;
    logic [LEN_W-1:0]    rrem_reg;
    logic [LEN_W-1:0]    open_reg;
    logic [LEN_W-1:0]    hdr_reg;
    logic                ones_reg;
    logic                skip_reg;
    logic [ST_W-1:0]     pst_reg;
    logic [DATA_W-1:0]   pdata_reg;
    logic                plast_reg;
    logic [LEN_W-1:0]    plen_reg;
    logic                out_valid_reg;
    logic [ST_W-1:0]     status_reg;
    logic [DATA_W-1:0]   data_out_reg;
    logic                last_byte_reg;
    logic [LEN_W-1:0]    read_length_reg;

    logic [DATA_W-1:0]   mem [BUF_BYTES];
    logic [DATA_W-1:0]   rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [DATA_W-1:0]   mem_wdata;

    logic [CW-1:0]       total;
    logic [CW-1:0]       head_room;
    logic [CW-1:0]       tail_gap;
    logic [AW-1:0]       wp_k;
    logic [AW-1:0]       rp_k;
    logic [AW-1:0]       wp_inc;
    logic [AW-1:0]       rp_inc;
    logic [AW-1:0]       wp_hdr;
    logic [AW-1:0]       rp_hdr;
    logic [31:0]         len_shift;
    logic [31:0]         byte_shift;
    logic                ones_n;
    logic [LEN_W-1:0]    hdr_n;
    logic                load_out;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] step);
        logic [AW:0] s;
        begin
            s = {1'b0, base} + {1'b0, step};
            if (s >= (AW+1)'(BUF_BYTES))
                s = s - (AW+1)'(BUF_BYTES);
            wrap_add = s[AW-1:0];
        end
    endfunction

    assign total     = CW'(it_reg.len) + HDR2_C;
    assign head_room = BUF_C - CW'(head_reg);
    assign tail_gap  = CW'(tail_reg) - CW'(head_reg);
    assign wp_k      = wrap_add(wp_reg, AW'(k_reg));
    assign rp_k      = wrap_add(rp_reg, AW'(k_reg));
    assign wp_inc    = wrap_add(wp_reg, AW'(1));
    assign rp_inc    = wrap_add(rp_reg, AW'(1));
    assign wp_hdr    = wrap_add(wp_reg, AW'(HDR_BYTES));
    assign rp_hdr    = wrap_add(rp_reg, AW'(HDR_BYTES));
    assign len_shift = 32'(it_reg.len) >> {k_reg, 3'b000};
    assign byte_shift = 32'(rdata_reg) << {k_reg, 3'b000};
    assign ones_n    = ((k_reg == '0) ? 1'b1 : ones_reg) && (rdata_reg == 8'hFF);
    assign hdr_n     = ((k_reg == '0) ? '0 : hdr_reg) | byte_shift[LEN_W-1:0];
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || pop);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = rp_reg;
        mem_wdata = it_reg.data;
        case (state_reg)
            S_WR:
            begin
                mem_we   = 1'b1;
                mem_addr = wp_reg;
            end
            S_MARK:
            begin
                mem_we    = 1'b1;
                mem_addr  = wp_k;
                mem_wdata = 8'hFF;
            end
            S_HDRW:
            begin
                mem_we    = 1'b1;
                mem_addr  = wp_k;
                mem_wdata = len_shift[DATA_W-1:0];
            end
            S_HRD:   mem_addr = rp_k;
            default: mem_addr = rp_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    assign item_take   = (state_reg == S_IDLE) && item_valid;
    assign empty       = !out_valid_reg;
    assign status      = status_reg;
    assign data_out    = data_out_reg;
    assign last_byte   = last_byte_reg;
    assign read_length = read_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            it_reg          <= '0;
            k_reg           <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            wrapped_reg     <= 1'b0;
            wp_reg          <= '0;
            wrem_reg        <= '0;
            rp_reg          <= '0;
            rrem_reg        <= '0;
            open_reg        <= '0;
            hdr_reg         <= '0;
            ones_reg        <= 1'b0;
            skip_reg        <= 1'b0;
            pst_reg         <= ST_OK;
            pdata_reg       <= '0;
            plast_reg       <= 1'b0;
            plen_reg        <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            data_out_reg    <= '0;
            last_byte_reg   <= 1'b0;
            read_length_reg <= '0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        it_reg    <= item;
                        k_reg     <= '0;
                        skip_reg  <= 1'b0;
                        pdata_reg <= '0;
                        plast_reg <= 1'b0;
                        plen_reg  <= '0;
                        pst_reg   <= ST_OK;
                        state_reg <= S_DONE;
                        case (item.op)
                            OP_RESERVE:
                            begin
                                if (item.zero_len)
                                    pst_reg <= ST_BADLEN;
                                else if (wrem_reg != '0)
                                    pst_reg <= ST_SEQ;
                                else if (head_reg >= tail_reg)
                                begin
                                    if (!wrapped_reg &&
                                        head_room > (CW'(item.len) + HDR2_C))
                                        state_reg <= S_HDRW;
                                    else if (tail_reg == '0)
                                        pst_reg <= ST_FULL;
                                    else
                                        state_reg <= S_MARK;
                                end
                                else if (tail_gap > (CW'(item.len) + HDR2_C))
                                    state_reg <= S_HDRW;
                                else
                                    pst_reg <= ST_FULL;
                            end
                            OP_WRITE:
                            begin
                                if (wrem_reg == '0)
                                    pst_reg <= ST_SEQ;
                                else
                                    state_reg <= S_WR;
                            end
                            OP_READ:
                            begin
                                if (rrem_reg != '0)
                                    state_reg <= S_BRD;
                                else if (tail_reg == head_reg)
                                    pst_reg <= ST_EMPTY;
                                else
                                    state_reg <= S_HRD;
                            end
                            default: pst_reg <= ST_SEQ;
                        endcase
                    end
                end
                S_WR:
                begin
                    wp_reg   <= wp_inc;
                    wrem_reg <= wrem_reg - LEN_W'(1);
                    if (wrem_reg == LEN_W'(1))
                        head_reg <= wp_inc;
                    state_reg <= S_DONE;
                end
                S_MARK:
                begin
                    if (k_reg == K_LAST)
                    begin
                        head_reg    <= '0;
                        wp_reg      <= '0;
                        wrapped_reg <= 1'b1;
                        k_reg       <= '0;
                        if (CW'(tail_reg) > total)
                            state_reg <= S_HDRW;
                        else
                        begin
                            pst_reg   <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                        k_reg <= k_reg + KW'(1);
                end
                S_HDRW:
                begin
                    if (k_reg == K_LAST)
                    begin
                        wp_reg    <= wp_hdr;
                        wrem_reg  <= it_reg.len;
                        state_reg <= S_DONE;
                    end
                    else
                        k_reg <= k_reg + KW'(1);
                end
                S_HRD:
                    state_reg <= S_HCOL;
                S_HCOL:
                begin
                    ones_reg <= ones_n;
                    hdr_reg  <= hdr_n;
                    if (k_reg != K_LAST)
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_HRD;
                    end
                    else if (ones_n)
                    begin
                        k_reg <= '0;
                        if (skip_reg)
                        begin
                            pst_reg   <= ST_EMPTY;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            wrapped_reg <= 1'b0;
                            rp_reg      <= '0;
                            tail_reg    <= '0;
                            skip_reg    <= 1'b1;
                            if (head_reg == '0)
                            begin
                                pst_reg   <= ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_HRD;
                        end
                    end
                    else if (hdr_n == '0)
                    begin
                        pst_reg   <= ST_EMPTY;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        open_reg  <= hdr_n;
                        rrem_reg  <= hdr_n;
                        rp_reg    <= rp_hdr;
                        state_reg <= S_BRD;
                    end
                end
                S_BRD:
                    state_reg <= S_BCOL;
                S_BCOL:
                begin
                    pdata_reg <= rdata_reg;
                    plen_reg  <= open_reg;
                    rp_reg    <= rp_inc;
                    rrem_reg  <= rrem_reg - LEN_W'(1);
                    if (rrem_reg == LEN_W'(1))
                    begin
                        plast_reg <= 1'b1;
                        tail_reg  <= rp_inc;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        status_reg      <= pst_reg;
                        data_out_reg    <= pdata_reg;
                        last_byte_reg   <= plast_reg;
                        read_length_reg <= plen_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ dv/variable_length_message_ring_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_length_message_ring_test
// Drives reserve, write, read and invalid words into the message ring with
// random gaps on both sides and checks every result word against a scoreboard
// that keeps its own copy of the ring, offsets and open message counts.
// ----------------------------------------------------------------------------
module variable_length_message_ring_test;
    import vlmr_pkg::*;

    localparam int RING_BYTES = 4096;
    localparam int HDR        = 4;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed
    {
        logic [ST_W-1:0]   st;
        logic [DATA_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  rlen;
    } answer_t;

    class ring_scoreboard;
        logic [7:0] ring [RING_BYTES];
        int unsigned head, tail, wrapped, wptr, wleft, rptr, rleft, olen;
        answer_t pending [$];
        int errors;
        int words_checked;

        function void clear();
            head = 0; tail = 0; wrapped = 0; wptr = 0;
            wleft = 0; rptr = 0; rleft = 0; olen = 0;
            errors = 0; words_checked = 0;
        endfunction

        function void put_hdr(int unsigned pos, logic [31:0] v);
            for (int i = 0; i < HDR; i++)
                ring[(pos + i) % RING_BYTES] = v[8*i +: 8];
        endfunction

        function logic [31:0] get_hdr(int unsigned pos, output bit ones);
            logic [31:0] v;
            v = '0;
            ones = 1;
            for (int i = 0; i < HDR; i++)
            begin
                if (ring[(pos + i) % RING_BYTES] != 8'hFF)
                    ones = 0;
                v[8*i +: 8] = ring[(pos + i) % RING_BYTES];
            end
            return v;
        endfunction

        function logic [ST_W-1:0] reserve(int unsigned len);
            int unsigned total;
            bit ok;
            total = len + 2 * HDR;
            ok = 0;
            if (len == 0)
                return ST_BADLEN;
            if (wleft != 0)
                return ST_SEQ;
            if (head >= tail)
            begin
                if (wrapped == 0 && RING_BYTES - head > total)
                    ok = 1;
                else
                begin
                    if (tail == 0)
                        return ST_FULL;
                    put_hdr(wptr, 32'hFFFF_FFFF);
                    head = 0; wptr = 0; wrapped = 1;
                end
            end
            if (!ok && tail > head && tail - head > total)
                ok = 1;
            if (!ok)
                return ST_FULL;
            put_hdr(wptr, len);
            wptr = (wptr + HDR) % RING_BYTES;
            wleft = len;
            return ST_OK;
        endfunction

        function void note_word(op_t op, logic [LEN_W-1:0] len, logic [7:0] din);
            answer_t a;
            logic [31:0] h;
            bit ones;
            a = '0;
            case (op)
                OP_RESERVE: a.st = reserve(len);
                OP_WRITE:
                    if (wleft == 0)
                        a.st = ST_SEQ;
                    else
                    begin
                        ring[wptr] = din;
                        wptr = (wptr + 1) % RING_BYTES;
                        wleft--;
                        if (wleft == 0)
                            head = wptr;
                        a.st = ST_OK;
                    end
                OP_READ:
                begin
                    a.st = ST_OK;
                    if (rleft == 0)
                    begin
                        if (tail == head)
                            a.st = ST_EMPTY;
                        else
                        begin
                            h = get_hdr(rptr, ones);
                            if (ones)
                            begin
                                wrapped = 0; rptr = 0; tail = 0;
                                if (head == 0)
                                    a.st = ST_EMPTY;
                                else
                                begin
                                    h = get_hdr(rptr, ones);
                                    if (ones)
                                        a.st = ST_EMPTY;
                                end
                            end
                            if (a.st == ST_OK && h == 0)
                                a.st = ST_EMPTY;
                            if (a.st == ST_OK)
                            begin
                                olen = h;
                                rleft = h;
                                rptr = (rptr + HDR) % RING_BYTES;
                            end
                        end
                    end
                    if (a.st == ST_OK)
                    begin
                        a.data = ring[rptr];
                        rptr = (rptr + 1) % RING_BYTES;
                        rleft--;
                        a.rlen = olen[LEN_W-1:0];
                        if (rleft == 0)
                        begin
                            a.last = 1;
                            tail = rptr;
                        end
                    end
                end
                default: a.st = ST_SEQ;
            endcase
            pending.push_back(a);
        endfunction

        function void check_word(answer_t got);
            answer_t want;
            words_checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.st !== want.st)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime, want.st, got.st);
                errors++;
            end
            if (got.data !== want.data)
            begin
                $display("%0t: data_out expected %h actual %h", $realtime, want.data, got.data);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_byte expected %b actual %b", $realtime, want.last, got.last);
                errors++;
            end
            if (got.rlen !== want.rlen)
            begin
                $display("%0t: read_length expected %0d actual %0d",
                         $realtime, want.rlen, got.rlen);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [1:0]        operation;
    logic [LEN_W-1:0]  msg_length;
    logic [DATA_W-1:0] data_in;
    logic              empty;
    logic              pop;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data_out;
    logic              last_byte;
    logic [LEN_W-1:0]  read_length;

    ring_scoreboard sb;
    int  cycles;
    bit  hold_reader;
    int  words_sent;

    variable_length_message_ring u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .msg_length  (msg_length),
        .data_in     (data_in),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .data_out    (data_out),
        .last_byte   (last_byte),
        .read_length (read_length)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    function int gap_length();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_word(op_t op, int unsigned len, int unsigned din);
        int g;
        g = gap_length();
        if (words_sent % 97 < 30)
            g = 0;
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push       <= 1'b1;
        operation  <= op;
        msg_length <= len[LEN_W-1:0];
        data_in    <= din[7:0];
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_word(op, len[LEN_W-1:0], din[7:0]);
        words_sent++;
    endtask

    task automatic send_message(int unsigned len, int unsigned extra_writes);
        send_word(OP_RESERVE, len, $urandom_range(0, 255));
        for (int i = 0; i < len + extra_writes; i++)
            send_word(OP_WRITE, $urandom_range(0, 4095), $urandom_range(0, 255));
    endtask

    task automatic send_reads(int n);
        for (int i = 0; i < n; i++)
            send_word(OP_READ, $urandom_range(0, 4095), $urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function int unsigned pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 12);
        if (r < 95)
            return $urandom_range(13, 300);
        return $urandom_range(1000, 4095);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : reader
        int g;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_word('{status, data_out, last_byte, read_length});
            if (hold_reader)
                pop <= 1'b0;
            else if (g > 0)
            begin
                g--;
                pop <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                g = gap_length();
                pop <= (g == 0);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : holder
        hold_reader = 0;
        @(posedge rst_n);
        repeat (2000) @(posedge clk);
        hold_reader = 1;
        repeat (400) @(posedge clk);
        hold_reader = 0;
    end

    initial
    begin : sender
        int op_pick;
        sb = new();
        sb.clear();
        words_sent = 0;
        push       <= 1'b0;
        operation  <= OP_RESERVE;
        msg_length <= '0;
        data_in    <= '0;
        rst_n      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_reads(1);
        send_word(OP_WRITE, 0, 8'hFF);
        send_word(OP_RESERVE, 0, 0);
        send_word(OP_BAD, 4095, 255);
        send_word(OP_RESERVE, 4095, 0);
        send_word(OP_RESERVE, 1, 0);
        send_word(OP_WRITE, 4095, 8'h00);
        send_message(1, 0);
        send_word(OP_RESERVE, 3, 0);
        send_word(OP_RESERVE, 3, 0);
        send_word(OP_WRITE, 0, 8'hFF);
        send_word(OP_WRITE, 0, 8'h55);
        send_word(OP_WRITE, 0, 8'hAA);
        send_reads(7);
        wait_drained();

        // random: mostly well-formed messages, some noise
        while (words_sent < 1600)
        begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 45)
                send_message(pick_length(), ($urandom_range(0, 9) == 0));
            else if (op_pick < 85)
                send_reads($urandom_range(1, 40));
            else if (op_pick < 90)
                send_word(OP_RESERVE, 0, $urandom_range(0, 255));
            else if (op_pick < 93)
                send_word(OP_BAD, $urandom_range(0, 4095), $urandom_range(0, 255));
            else if (op_pick < 96)
                send_word(OP_RESERVE, $urandom_range(1, 4095), 0);
            else if (op_pick < 98)
                send_word(OP_WRITE, $urandom_range(0, 4095), $urandom_range(0, 255));
            else
                wait_drained();
        end
        send_reads(300);
        wait_drained();
        repeat (50) @(posedge clk);
        $display("Sent %0d words, checked %0d result words.", words_sent, sb.words_checked);
        $display("Covered reserve, write, read, wraps, full, empty and sequence errors.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ variable_length_message_ring.f @@
sv/vlmr_pkg.sv
sv/vlmr_front.sv
sv/vlmr_back.sv
sv/variable_length_message_ring.sv
dv/variable_length_message_ring_test.sv
